// ----- rtl/rotation_bounding_square_top_assert.svh -----
// assertion macros used by the checker of the bounding square block
`ifndef ROTATION_BOUNDING_SQUARE_TOP_ASSERT_SVH
`define ROTATION_BOUNDING_SQUARE_TOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define RBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define RBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rbs_pkg.sv -----
package rbs_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FIELD_W        = 10;
    localparam int SIDE_W         = 12;
    localparam int OFFSET_W       = 11;

    typedef struct packed {
        logic [FIELD_W-1:0] pivot_x;
        logic [FIELD_W-1:0] pivot_y;
        logic [FIELD_W-1:0] bitmap_width;
        logic [FIELD_W-1:0] bitmap_height;
    } item_t;

    typedef struct packed {
        logic [SIDE_W-1:0]   frame_side;
        logic [OFFSET_W-1:0] centre_offset;
    } result_t;

endpackage

// ----- rtl/rbs_cell.sv -----
module rbs_cell
    import rbs_pkg::*;
#(
    parameter int ROOT_W = COORD_BITS_DEF + 1,
    localparam int RAD_W  = 2 * ROOT_W,
    localparam int REM_W  = ROOT_W + 2,
    localparam int CAND_W = REM_W + 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [REM_W-1:0]  in_rem,
    input  logic [ROOT_W-1:0] in_root,
    output logic              out_valid,
    output logic [RAD_W-1:0]  out_rad,
    output logic [REM_W-1:0]  out_rem,
    output logic [ROOT_W-1:0] out_root
);

    logic              valid_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [CAND_W-1:0] cand;
    logic [CAND_W-1:0] trial;
    logic [CAND_W-1:0] diff;
    logic              fit;
    logic [RAD_W-1:0]  rad_next;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // bring down the next two radicand bits and try root*4+1
    assign cand  = {in_rem, in_rad[RAD_W-1 -: 2]};
    assign trial = CAND_W'({in_root, 2'b01});
    assign diff  = cand - trial;
    assign fit   = (cand >= trial);

    assign rad_next  = {in_rad[RAD_W-3:0], 2'b00};
    assign rem_next  = fit ? REM_W'(diff) : REM_W'(cand);
    assign root_next = {in_root[ROOT_W-2:0], fit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;

endmodule

// ----- rtl/rbs_front.sv -----
module rbs_front
    import rbs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int SQ_W  = 2 * COORD_BITS,
    localparam int RAD_W = 2 * COORD_BITS + 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             advance,
    input  item_t            item,
    output logic             valid,
    output logic [RAD_W-1:0] rad
);

    function automatic logic [COORD_BITS-1:0] extent(
        input logic [COORD_BITS-1:0] pivot,
        input logic [COORD_BITS-1:0] size
    );
        logic [COORD_BITS-1:0] far;
        begin
            far    = (size >= pivot) ? (size - pivot) : (pivot - size);
            extent = (pivot > far) ? pivot : far;
        end
    endfunction

    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] bw;
    logic [COORD_BITS-1:0] bh;

    logic                  ext_valid_reg;
    logic [COORD_BITS-1:0] hz_reg;
    logic [COORD_BITS-1:0] vt_reg;
    logic                  sq_valid_reg;
    logic [SQ_W-1:0]       hsq_reg;
    logic [SQ_W-1:0]       vsq_reg;
    logic                  sum_valid_reg;
    logic [RAD_W-1:0]      sum_reg;

    assign px = COORD_BITS'(item.pivot_x);
    assign py = COORD_BITS'(item.pivot_y);
    assign bw = COORD_BITS'(item.bitmap_width);
    assign bh = COORD_BITS'(item.bitmap_height);

    // the extent stage loads on accept even while the chain is held, it is empty then
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_valid_reg <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                ext_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                ext_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                sq_valid_reg  <= ext_valid_reg;
                sum_valid_reg <= sq_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hz_reg <= extent(px, bw);
            vt_reg <= extent(py, bh);
        end
        if (advance)
        begin
            hsq_reg <= SQ_W'(hz_reg) * SQ_W'(hz_reg);
            vsq_reg <= SQ_W'(vt_reg) * SQ_W'(vt_reg);
            sum_reg <= RAD_W'(hsq_reg) + RAD_W'(vsq_reg);
        end
    end

    assign valid = sum_valid_reg;
    assign rad   = sum_reg;

endmodule

// ----- rtl/rotation_bounding_square_top.sv -----
// path from request accept to result valid: extent, square and sum stages, one
// root digit per cell along the cell row, then the result register; a new request
// is taken only once the previous one has left the cell row
// one request in flight; a stalled result holds the whole row
// reset clears the valid flags and busy state, datapath registers are not reset
module rotation_bounding_square_top
    import rbs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int ROOT_W = COORD_BITS + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;

    logic              accept;
    logic              advance;
    logic              busy_reg;
    logic              busy_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    result_t           result_reg;
    logic              last_valid;

    logic              valid_chain [ROOT_W+1];
    logic [RAD_W-1:0]  rad_chain   [ROOT_W+1];
    logic [REM_W-1:0]  rem_chain   [ROOT_W+1];
    logic [ROOT_W-1:0] root_chain  [ROOT_W+1];

    assign accept  = item_valid && !busy_reg;
    assign advance = !(result_valid_reg && result_stall);

    rbs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .advance (advance),
        .item    (item),
        .valid   (valid_chain[0]),
        .rad     (rad_chain[0])
    );

    assign rem_chain[0]  = '0;
    assign root_chain[0] = '0;

    // one cell per root digit, most significant first
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        rbs_cell #(
            .ROOT_W (ROOT_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (valid_chain[i]),
            .in_rad    (rad_chain[i]),
            .in_rem    (rem_chain[i]),
            .in_root   (root_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_rad   (rad_chain[i+1]),
            .out_rem   (rem_chain[i+1]),
            .out_root  (root_chain[i+1])
        );
    end

    assign last_valid = valid_chain[ROOT_W];

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (last_valid && advance)
        begin
            busy_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (last_valid && advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_valid && advance)
        begin
            result_reg.frame_side    <= SIDE_W'({root_chain[ROOT_W], 1'b1});
            result_reg.centre_offset <= OFFSET_W'(root_chain[ROOT_W]);
        end
    end

    assign item_stall   = busy_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- rtl/rbs_checker.sv -----
`include "rotation_bounding_square_top_assert.svh"

module rbs_checker
    import rbs_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    logic item_taken;

    assign item_taken = item_valid && !item_stall;

    `RBS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")
    `RBS_ASSERT_SAME(a_side_odd, result_valid, result.frame_side[0], "frame side is even")
    `RBS_ASSERT_SAME(a_offset_half, result_valid, result.centre_offset == result.frame_side[SIDE_W-1:1], "centre offset is not half the frame side")
    `RBS_ASSERT_NEXT(a_one_in_flight, item_taken, item_stall, "second request taken while one is in flight")

endmodule

bind rotation_bounding_square_top rbs_checker u_rbs_checker (.*);

// ----- bench/rbs_checker.sv -----
`timescale 1ns / 100ps

module tb_rbs_checker
    import rbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      failures,
    output int      pending,
    output int      frames_checked
);

    localparam logic [63:0] COORD_MASK = (64'd1 << COORD_BITS_DEF) - 64'd1;

    result_t frame_expected[$];

    initial begin
        failures       = 0;
        pending        = 0;
        frames_checked = 0;
    end

    // larger of the pivot and its absolute distance to the far edge
    function automatic logic [63:0] span_of(input logic [63:0] pivot, input logic [63:0] size);
        logic [63:0] far_dist;
        far_dist = (size >= pivot) ? (size - pivot) : (pivot - size);
        return (pivot > far_dist) ? pivot : far_dist;
    endfunction

    // exact floor root, two radicand bits per digit
    function automatic logic [63:0] isqrt_floor(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] trial;
        rem  = '0;
        root = '0;
        for (int i = 15; i >= 0; i--) begin
            rem   = (rem << 2) | ((n >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            root  = root << 1;
            if (rem >= trial) begin
                rem     = rem - trial;
                root[0] = 1'b1;
            end
        end
        return root;
    endfunction

    function automatic result_t predict_frame(input item_t req);
        logic [63:0] hz;
        logic [63:0] vt;
        logic [63:0] side;
        result_t     res;
        hz   = span_of(64'(req.pivot_x) & COORD_MASK, 64'(req.bitmap_width) & COORD_MASK);
        vt   = span_of(64'(req.pivot_y) & COORD_MASK, 64'(req.bitmap_height) & COORD_MASK);
        side = 64'd2 * isqrt_floor(hz * hz + vt * vt) + 64'd1;
        res.frame_side    = side[SIDE_W-1:0];
        res.centre_offset = side[OFFSET_W:1];
        return res;
    endfunction

    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (item_valid && !item_stall)
                frame_expected.push_back(predict_frame(item));
            if (result_valid && !result_stall) begin
                if (frame_expected.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual side %0d offset %0d",
                             $time, result.frame_side, result.centre_offset);
                    failures++;
                end
                else begin
                    want = frame_expected.pop_front();
                    frames_checked++;
                    if (result.frame_side !== want.frame_side) begin
                        $display("%0t frame_side mismatch: expected %0d actual %0d",
                                 $time, want.frame_side, result.frame_side);
                        failures++;
                    end
                    if (result.centre_offset !== want.centre_offset) begin
                        $display("%0t centre_offset mismatch: expected %0d actual %0d",
                                 $time, want.centre_offset, result.centre_offset);
                        failures++;
                    end
                end
            end
            pending <= frame_expected.size();
        end
    end

endmodule

// ----- bench/tb_rotation_bounding_square_top.sv -----
`timescale 1ns / 100ps

module tb_rotation_bounding_square_top;
    import rbs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_MIX = 260;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 20;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_stall;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int failures;
    int pending;
    int frames_checked;
    int cycle_count   = 0;
    int requests_sent = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    bit hold_go       = 1'b0;

    rotation_bounding_square_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    tb_rbs_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .failures       (failures),
        .pending        (pending),
        .frames_checked (frames_checked)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("FAIL rotation_bounding_square_top");
        $finish;
    end

    // output side: random stalls, plus one long hold-off that backs up the block
    initial begin
        bit hold_done;
        int hold_left;
        hold_done = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    function automatic item_t mk_item(input int px, input int py, input int w, input int h);
        item_t it;
        it.pivot_x       = px[FIELD_W-1:0];
        it.pivot_y       = py[FIELD_W-1:0];
        it.bitmap_width  = w[FIELD_W-1:0];
        it.bitmap_height = h[FIELD_W-1:0];
        return it;
    endfunction

    function automatic int edge_value();
        int pick;
        pick = $urandom_range(4);
        case (pick)
            0:       return 0;
            1:       return 1;
            2:       return 1022;
            3:       return 1023;
            default: return $urandom_range(1023);
        endcase
    endfunction

    function automatic item_t rand_item();
        int kind;
        int w;
        int h;
        item_t it;
        kind = $urandom_range(99);
        if (kind < 70) begin
            // pivot inside the bitmap, the usual case
            w  = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1023);
            h  = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1023);
            it = mk_item($urandom_range(w), $urandom_range(h), w, h);
        end
        else if (kind < 85)
            it = item_t'((4*FIELD_W)'({$urandom, $urandom}));
        else
            it = mk_item(edge_value(), edge_value(), edge_value(), edge_value());
        return it;
    endfunction

    task automatic send_request(input item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic run_mix(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int n = 0; n < ITEMS_PER_MIX; n++)
            send_request(rand_item());
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_request(mk_item(0, 0, 0, 0));
        send_request(mk_item(1023, 1023, 1023, 1023));
        send_request(mk_item(0, 0, 1023, 1023));
        send_request(mk_item(1023, 1023, 0, 0));
        send_request(mk_item(512, 512, 1023, 1023));
        send_request(mk_item(1, 0, 1, 0));
        send_request(mk_item(1, 1, 0, 0));
        send_request(mk_item(2, 2, 4, 4));
        send_request(mk_item(3, 4, 6, 8));
        send_request(mk_item(700, 20, 100, 10));
        send_request(mk_item(5, 900, 3, 40));
        send_request(mk_item(0, 0, 1, 1));
        send_request(mk_item(0, 0, 15, 0));
        send_request(mk_item(0, 0, 16, 0));
        send_request(mk_item(341, 682, 682, 341));
        send_request(mk_item(1023, 0, 1023, 1023));
        send_request(mk_item(10'h2AA, 10'h155, 10'h155, 10'h2AA));
        send_request(mk_item(10'h155, 10'h2AA, 10'h2AA, 10'h155));

        hold_go = 1'b1;
        run_mix(0, 0);
        run_mix(48, 0);
        run_mix(0, 48);
        run_mix(19, 19);
        item_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests over four idle mixes and one long output hold-off",
                 requests_sent);
        $display("checked %0d frames, %0d mismatches", frames_checked, failures);
        if (failures == 0)
            $display("PASS rotation_bounding_square_top");
        else
            $display("FAIL rotation_bounding_square_top");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rbs_pkg.sv
rtl/rbs_cell.sv
rtl/rbs_front.sv
rtl/rotation_bounding_square_top.sv
rtl/rbs_checker.sv
bench/rbs_checker.sv
bench/tb_rotation_bounding_square_top.sv
